FILE: sv/qau_pkg.sv
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, opcodes and helpers for the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package qau_pkg;

    // default fraction width of the Q format
    localparam int FRAC_BITS_DEF = 28;
    localparam int LANES         = 4;
    localparam int MAX_ROWS      = 3;

    localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
    localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        OP_MUL   = 3'd0,
        OP_ADD   = 3'd1,
        OP_SCALE = 3'd2,
        OP_DOT   = 3'd3,
        OP_INV   = 3'd4,
        OP_NORM  = 3'd5,
        OP_MAT   = 3'd6,
        OP_RSVD  = 3'd7
    } op_t;

    // sequencer for the inverse / normalize path
    typedef enum logic [1:0] {
        SLOW_IDLE,
        SLOW_SQRT,
        SLOW_DIV,
        SLOW_DONE
    } slow_state_t;

    typedef struct packed {
        logic        [2:0]  req_type;
        logic signed [31:0] a_w;
        logic signed [31:0] a_x;
        logic signed [31:0] a_y;
        logic signed [31:0] a_z;
        logic signed [31:0] b_w;
        logic signed [31:0] b_x;
        logic signed [31:0] b_y;
        logic signed [31:0] b_z;
    } req_t;

    typedef struct packed {
        logic signed [31:0] res_a;
        logic signed [31:0] res_b;
        logic signed [31:0] res_c;
        logic signed [31:0] res_d;
        logic signed [31:0] res_scalar;
        logic               zero_norm_error;
        logic               last_of_run;
    } res_t;

    // multiplier lane stage enables
    typedef struct packed {
        logic mul_en;
        logic rnd_en;
    } lane_en_t;

    // divider lane controls
    typedef struct packed {
        logic load;
        logic step;
    } div_ctl_t;

    // clamp to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end
        else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end
        else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/qau_mul_lane.sv
// ----------------------------------------------------------------------------
// qau_mul_lane
// One operand component times four components: registered products, then
// registered round-half-up to the Q format.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_mul_lane
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                          clk,
    input  wire lane_en_t                      en,
    input  wire logic signed [31:0]            a,
    input  wire logic [LANES-1:0][31:0]        v,
    output logic [LANES-1:0][64-FRAC_BITS-1:0] rnd
);

    localparam int PW = 64 - FRAC_BITS;
    localparam logic signed [63:0] RND_BIAS = 64'sd1 <<< (FRAC_BITS - 1);

    logic signed [63:0]          prod_reg  [LANES];
    logic signed [63:0]          prod_next [LANES];
    logic [LANES-1:0][PW-1:0]    rnd_reg;
    logic [LANES-1:0][PW-1:0]    rnd_next;

    // full 64-bit products
    always_comb
    begin
        for (int j = 0; j < LANES; j++) begin
            prod_next[j] = a * $signed(v[j]);
        end
    end

    // round half up, drop fraction
    always_comb
    begin
        logic signed [63:0] biased;
        logic signed [63:0] shifted;
        biased  = '0;
        shifted = '0;
        for (int j = 0; j < LANES; j++) begin
            biased      = prod_reg[j] + RND_BIAS;
            shifted     = biased >>> FRAC_BITS;
            rnd_next[j] = shifted[PW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en.mul_en) begin
            prod_reg <= prod_next;
        end
        if (en.rnd_en) begin
            rnd_reg <= rnd_next;
        end
    end

    assign rnd = rnd_reg;

endmodule

`default_nettype wire

FILE: sv/qau_isqrt.sv
// ----------------------------------------------------------------------------
// qau_isqrt
// Floor square root of a 64-bit value, two radicand bits per cycle,
// and a pulse on done.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_isqrt
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    input  wire logic [63:0] value,
    output logic             done,
    output logic [31:0]      root
);

    localparam logic [63:0] TOP_BIT = 64'h4000_0000_0000_0000;

    logic [63:0] val_reg,  val_next;
    logic [63:0] r_reg,    r_next;
    logic [63:0] step_bit_reg, step_bit_next;
    logic        busy_reg, busy_next;
    logic        done_reg, done_next;

    // one digit step
    always_comb
    begin
        logic [63:0] trial;
        trial         = r_reg + step_bit_reg;
        val_next      = val_reg;
        r_next        = r_reg;
        step_bit_next = step_bit_reg;
        busy_next     = busy_reg;
        done_next     = 1'b0;
        if (start) begin
            val_next      = value;
            r_next        = '0;
            step_bit_next = TOP_BIT;
            busy_next     = 1'b1;
        end
        else if (busy_reg) begin
            if (val_reg >= trial) begin
                val_next = val_reg - trial;
                r_next   = (r_reg >> 1) + step_bit_reg;
            end
            else begin
                r_next = r_reg >> 1;
            end
            step_bit_next = step_bit_reg >> 2;
            if (step_bit_reg == 64'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg      <= val_next;
        r_reg        <= r_next;
        step_bit_reg <= step_bit_next;
    end

    assign done = done_reg;
    assign root = r_reg[31:0];

endmodule

`default_nettype wire

FILE: sv/qau_div_lane.sv
// ----------------------------------------------------------------------------
// qau_div_lane
// Restoring divider, one quotient bit per step: (mag * 2^F) / divisor,
// truncated toward zero, signed and saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_div_lane
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic                        clk,
    input  wire div_ctl_t                    ctl,
    input  wire logic [31:0]                 num_mag,
    input  wire logic                        num_neg,
    input  wire logic [66-FRAC_BITS-1:0]     divisor,
    output logic signed [31:0]               quot
);

    localparam int DVW = 66 - FRAC_BITS;
    localparam int QW  = 32 + FRAC_BITS;

    logic [QW-1:0]  q_reg,   q_next;
    logic [DVW-1:0] rem_reg, rem_next;
    logic           neg_reg, neg_next;

    // shift-subtract step
    always_comb
    begin
        logic [DVW:0]   rem_sh;
        logic [DVW+1:0] diff;
        rem_sh   = {rem_reg, q_reg[QW-1]};
        diff     = {1'b0, rem_sh} - {2'b00, divisor};
        q_next   = q_reg;
        rem_next = rem_reg;
        neg_next = neg_reg;
        if (ctl.load) begin
            q_next   = QW'(num_mag) << FRAC_BITS;
            rem_next = '0;
            neg_next = num_neg;
        end
        else if (ctl.step) begin
            q_next   = {q_reg[QW-2:0], ~diff[DVW+1]};
            rem_next = diff[DVW+1] ? rem_sh[DVW-1:0] : diff[DVW-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    // apply sign and saturate
    always_comb
    begin
        logic hi;
        hi = |q_reg[QW-1:32];
        if (neg_reg) begin
            if (hi || (q_reg[31] && |q_reg[30:0])) begin
                quot = 32'sh8000_0000;
            end
            else begin
                quot = -$signed(q_reg[31:0]);
            end
        end
        else begin
            if (hi || q_reg[31]) begin
                quot = 32'sh7FFF_FFFF;
            end
            else begin
                quot = $signed(q_reg[31:0]);
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/quaternion_arithmetic_unit.sv
// Path: a request goes from s1 (products) to s2 (rounding, merge) to the output
//   register; inverse waits in s2 for the divider, normalize for root and divider.
// Throughput: one request per cycle while res_ready is high; a matrix op gives 3 rows;
//   inverse and normalize hold the pipe while the shared root/divider unit runs.
// Reset: rst_n, asynchronous active low, clears stage valids, the divider
//   sequencer and the output row index.
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Quaternion ALU: four multiplier lanes (one per component of a), a merge
// stage that forms the op result, and an iterative root/divide path.
// ----------------------------------------------------------------------------
`default_nettype none

module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    output logic      req_ready,
    input  wire req_t req_data,
    output logic      res_valid,
    input  wire logic res_ready,
    output res_t      res_data
);

    localparam int PW  = 64 - FRAC_BITS;
    localparam int SW  = PW + 4;
    localparam int DVW = 66 - FRAC_BITS;
    localparam int QW  = 32 + FRAC_BITS;
    localparam int CW  = $clog2(QW);
    localparam logic signed [SW-1:0] ONE_Q =
        {{(SW-FRAC_BITS-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};

    // pipeline control
    logic        s1_valid_reg, s1_valid_next;
    logic        s2_valid_reg, s2_valid_next;
    logic        s1_en, s2_en;
    req_t        s1_req_reg, s2_req_reg;
    logic [2:0]  s2_op;
    lane_en_t    lane_en;

    // output stage
    res_t        out_item_reg [MAX_ROWS];
    res_t        item         [MAX_ROWS];
    logic [1:0]  item_last;
    logic [1:0]  out_last_reg, out_last_next;
    logic [1:0]  out_idx_reg,  out_idx_next;
    logic        res_valid_reg, res_valid_next;
    logic        out_free, out_load, s2_go;

    // lanes
    logic [LANES-1:0][31:0]                 a_vec, v_vec;
    logic                                   use_a;
    logic [LANES-1:0][LANES-1:0][PW-1:0]    rnd;
    logic signed [SW-1:0]                   p [LANES][LANES];
    logic signed [SW-1:0]                   n_sum;
    logic                                   n_pos;

    // slow path
    slow_state_t               state_reg, state_next;
    logic                      slow_op;
    logic                      sqrt_start, sqrt_done;
    logic [63:0]               sqrt_in;
    logic [31:0]               sqrt_root;
    logic                      div_start;
    div_ctl_t                  div_ctl;
    logic [DVW-1:0]            div_dvs_reg, div_dvs_next;
    logic [CW-1:0]             div_cnt_reg, div_cnt_next;
    logic                      div_last;
    logic [LANES-1:0][31:0]    num_mag;
    logic [LANES-1:0]          num_neg;
    logic signed [31:0]        div_q [LANES];

    // ------------------------------------------------------------------
    // handshake and stage advance
    // ------------------------------------------------------------------
    assign s2_op    = s2_req_reg.req_type;
    assign s2_go    = s2_valid_reg && (!slow_op || state_reg == SLOW_DONE);
    assign out_free = !res_valid_reg || (res_ready && out_idx_reg == out_last_reg);
    assign out_load = s2_go && out_free;
    assign s2_en    = !s2_valid_reg || out_load;
    assign s1_en    = !s1_valid_reg || s2_en;
    assign req_ready = s1_en;

    assign s1_valid_next = s1_en ? req_valid : s1_valid_reg;
    assign s2_valid_next = s2_en ? s1_valid_reg : s2_valid_reg;

    always_ff @(posedge clk)
    begin
        if (s1_en) begin
            s1_req_reg <= req_data;
        end
        if (s2_en) begin
            s2_req_reg <= s1_req_reg;
        end
    end

    // ------------------------------------------------------------------
    // multiplier lanes: lane i is a_i times b (or a for inv/norm/matrix ops)
    // ------------------------------------------------------------------
    always_comb
    begin
        use_a = req_data.req_type inside {OP_INV, OP_NORM, OP_MAT};
        a_vec = {req_data.a_z, req_data.a_y, req_data.a_x, req_data.a_w};
        v_vec = use_a ? a_vec
                      : {req_data.b_z, req_data.b_y, req_data.b_x, req_data.b_w};
    end

    assign lane_en.mul_en = s1_en;
    assign lane_en.rnd_en = s2_en;

    for (genvar gi = 0; gi < LANES; gi++) begin : g_lane
        qau_mul_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .clk (clk),
            .en  (lane_en),
            .a   ($signed(a_vec[gi])),
            .v   (v_vec),
            .rnd (rnd[gi])
        );
    end

    always_comb
    begin
        for (int i = 0; i < LANES; i++) begin
            for (int j = 0; j < LANES; j++) begin
                p[i][j] = SW'($signed(rnd[i][j]));
            end
        end
    end

    // diagonal sum: dot product, or squared norm when lanes saw a*a
    assign n_sum = p[0][0] + p[1][1] + p[2][2] + p[3][3];
    assign n_pos = n_sum > 0;
    assign slow_op = s2_valid_reg && (s2_op == OP_INV || s2_op == OP_NORM) && n_pos;

    // ------------------------------------------------------------------
    // root / divide sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SLOW_IDLE: begin
                if (slow_op) begin
                    state_next = (s2_op == OP_NORM) ? SLOW_SQRT : SLOW_DIV;
                end
            end
            SLOW_SQRT: begin
                if (sqrt_done) begin
                    state_next = SLOW_DIV;
                end
            end
            SLOW_DIV: begin
                if (div_last) begin
                    state_next = SLOW_DONE;
                end
            end
            SLOW_DONE: begin
                if (out_load) begin
                    state_next = SLOW_IDLE;
                end
            end
            default: state_next = SLOW_IDLE;
        endcase
    end

    always_comb
    begin
        sqrt_start = 1'b0;
        div_start  = 1'b0;
        case (state_reg)
            SLOW_IDLE: begin
                sqrt_start = slow_op && s2_op == OP_NORM;
                div_start  = slow_op && s2_op == OP_INV;
            end
            SLOW_SQRT: begin
                div_start = sqrt_done;
            end
            default: begin
                sqrt_start = 1'b0;
                div_start  = 1'b0;
            end
        endcase
    end

    assign div_ctl.load = div_start;
    assign div_ctl.step = (state_reg == SLOW_DIV);
    assign div_last     = div_cnt_reg == CW'(QW - 1);

    // divisor: squared norm for inverse, twice the root for normalize
    always_comb
    begin
        div_dvs_next = div_dvs_reg;
        if (div_start) begin
            div_dvs_next = (state_reg == SLOW_SQRT) ? DVW'({sqrt_root, 1'b0})
                                                    : DVW'(unsigned'(n_sum));
        end
    end

    always_comb
    begin
        div_cnt_next = div_cnt_reg;
        if (div_ctl.load) begin
            div_cnt_next = '0;
        end
        else if (div_ctl.step) begin
            div_cnt_next = div_cnt_reg + CW'(1);
        end
    end

    assign sqrt_in = 64'(unsigned'(n_sum)) << (FRAC_BITS - 2);

    qau_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sqrt_start),
        .value (sqrt_in),
        .done  (sqrt_done),
        .root  (sqrt_root)
    );

    // numerators: a for normalize, conjugate of a for inverse
    always_comb
    begin
        logic signed [32:0] num [LANES];
        logic signed [32:0] mag;
        logic               conj;
        conj   = (s2_op == OP_INV);
        num[0] = 33'(s2_req_reg.a_w);
        num[1] = conj ? -33'(s2_req_reg.a_x) : 33'(s2_req_reg.a_x);
        num[2] = conj ? -33'(s2_req_reg.a_y) : 33'(s2_req_reg.a_y);
        num[3] = conj ? -33'(s2_req_reg.a_z) : 33'(s2_req_reg.a_z);
        mag    = '0;
        for (int i = 0; i < LANES; i++) begin
            num_neg[i] = num[i][32];
            mag        = num[i][32] ? -num[i] : num[i];
            num_mag[i] = mag[31:0];
        end
    end

    for (genvar gd = 0; gd < LANES; gd++) begin : g_div
        qau_div_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_div (
            .clk     (clk),
            .ctl     (div_ctl),
            .num_mag (num_mag[gd]),
            .num_neg (num_neg[gd]),
            .divisor (div_dvs_reg),
            .quot    (div_q[gd])
        );
    end

    // ------------------------------------------------------------------
    // merge: combine lane products into result items
    // ------------------------------------------------------------------
    always_comb
    begin
        logic signed [SW-1:0] m_a, m_b, m_c, m_d;
        logic signed [SW-1:0] twx, twy, twz, txx, txy, txz, tyy, tyz, tzz;
        m_a = p[0][0] - p[1][1] - p[2][2] - p[3][3];
        m_b = p[0][1] + p[1][0] + p[2][3] - p[3][2];
        m_c = p[0][2] + p[2][0] + p[3][1] - p[1][3];
        m_d = p[0][3] + p[3][0] + p[1][2] - p[2][1];
        twx = p[1][0] <<< 1;
        twy = p[2][0] <<< 1;
        twz = p[3][0] <<< 1;
        txx = p[1][1] <<< 1;
        txy = p[2][1] <<< 1;
        txz = p[3][1] <<< 1;
        tyy = p[2][2] <<< 1;
        tyz = p[3][2] <<< 1;
        tzz = p[3][3] <<< 1;
        for (int k = 0; k < MAX_ROWS; k++) begin
            item[k] = '0;
        end
        item[0].last_of_run = 1'b1;
        item_last = 2'd0;
        case (s2_op)
            OP_MUL: begin
                item[0].res_a = sat32(64'(m_a));
                item[0].res_b = sat32(64'(m_b));
                item[0].res_c = sat32(64'(m_c));
                item[0].res_d = sat32(64'(m_d));
            end
            OP_ADD: begin
                item[0].res_a = sat32(64'(s2_req_reg.a_w) + 64'(s2_req_reg.b_w));
                item[0].res_b = sat32(64'(s2_req_reg.a_x) + 64'(s2_req_reg.b_x));
                item[0].res_c = sat32(64'(s2_req_reg.a_y) + 64'(s2_req_reg.b_y));
                item[0].res_d = sat32(64'(s2_req_reg.a_z) + 64'(s2_req_reg.b_z));
            end
            OP_SCALE: begin
                item[0].res_a = sat32(64'(p[0][0]));
                item[0].res_b = sat32(64'(p[1][0]));
                item[0].res_c = sat32(64'(p[2][0]));
                item[0].res_d = sat32(64'(p[3][0]));
            end
            OP_DOT: begin
                item[0].res_scalar = sat32(64'(n_sum));
            end
            OP_INV, OP_NORM: begin
                if (n_pos) begin
                    item[0].res_a = div_q[0];
                    item[0].res_b = div_q[1];
                    item[0].res_c = div_q[2];
                    item[0].res_d = div_q[3];
                    if (s2_op == OP_NORM) begin
                        item[0].res_scalar = sat32(64'(n_sum));
                    end
                end
                else begin
                    item[0].zero_norm_error = 1'b1;
                end
            end
            OP_MAT: begin
                item_last = 2'd2;
                item[0].last_of_run = 1'b0;
                item[0].res_a = sat32(64'(ONE_Q - (tyy + tzz)));
                item[0].res_b = sat32(64'(txy + twz));
                item[0].res_c = sat32(64'(txz - twy));
                item[1].res_a = sat32(64'(txy - twz));
                item[1].res_b = sat32(64'(ONE_Q - (txx + tzz)));
                item[1].res_c = sat32(64'(tyz + twx));
                item[2].last_of_run = 1'b1;
                item[2].res_a = sat32(64'(txz + twy));
                item[2].res_b = sat32(64'(tyz - twx));
                item[2].res_c = sat32(64'(ONE_Q - (txx + tyy)));
            end
            default: begin
                item_last = 2'd0;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // output register, one row per handshake
    // ------------------------------------------------------------------
    always_comb
    begin
        res_valid_next = res_valid_reg;
        out_idx_next   = out_idx_reg;
        out_last_next  = out_last_reg;
        if (out_load) begin
            res_valid_next = 1'b1;
            out_idx_next   = 2'd0;
            out_last_next  = item_last;
        end
        else if (res_valid_reg && res_ready) begin
            if (out_idx_reg == out_last_reg) begin
                res_valid_next = 1'b0;
            end
            else begin
                out_idx_next = out_idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load) begin
            out_item_reg <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            out_idx_reg   <= 2'd0;
            out_last_reg  <= 2'd0;
            state_reg     <= SLOW_IDLE;
            div_cnt_reg   <= '0;
            div_dvs_reg   <= '0;
        end
        else begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            res_valid_reg <= res_valid_next;
            out_idx_reg   <= out_idx_next;
            out_last_reg  <= out_last_next;
            state_reg     <= state_next;
            div_cnt_reg   <= div_cnt_next;
            div_dvs_reg   <= div_dvs_next;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = out_item_reg[out_idx_reg];

endmodule

`default_nettype wire

FILE: sv/qau_checker.sv
// ----------------------------------------------------------------------------
// qau_checker
// Port-level checks of the quaternion arithmetic unit, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_checker
    import qau_pkg::*;
(
    input wire logic clk,
    input wire logic rst_n,
    input wire logic req_valid,
    input wire logic req_ready,
    input wire req_t req_data,
    input wire logic res_valid,
    input wire logic res_ready,
    input wire res_t res_data
);

    // stalled result holds
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("result changed while stalled");

    // matrix rows follow each other without a gap
    a_rows_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_ready && !res_data.last_of_run |=> res_valid)
        else $error("missing matrix row after non-final row");

    // zero-norm error returns an all-zero single item
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.zero_norm_error |->
            res_data.res_a == 0 && res_data.res_b == 0 && res_data.res_c == 0 &&
            res_data.res_d == 0 && res_data.res_scalar == 0 && res_data.last_of_run)
        else $error("zero-norm result not cleared");

    // non-final rows are matrix rows only
    a_row_fields: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.last_of_run |->
            res_data.res_d == 0 && res_data.res_scalar == 0 &&
            !res_data.zero_norm_error)
        else $error("bad fields in matrix row");

endmodule

bind quaternion_arithmetic_unit qau_checker u_qau_checker (.*);

`default_nettype wire

FILE: test/qau_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// qau_scoreboard
// Watches both channels of the quaternion unit, predicts the result rows of
// every accepted request and compares them in order, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module qau_scoreboard
    import qau_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic req_valid,
    input  wire logic req_ready,
    input  wire req_t req_data,
    input  wire logic res_valid,
    input  wire logic res_ready,
    input  wire res_t res_data,
    output int        errors,
    output int        pending,
    output int        rows_seen
);

    localparam int FB = FRAC_BITS_DEF;

    res_t rows_due[$];

    // Q-format product, round half up
    function automatic logic signed [63:0] qmul(input logic signed [63:0] u,
                                                input logic signed [63:0] v);
        logic signed [63:0] p;
        p = u * v + (64'sd1 <<< (FB - 1));
        return p >>> FB;
    endfunction

    function automatic logic signed [31:0] clamp(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic res_t mk_row(input logic signed [63:0] a, b, c, d, s,
                                    input logic err, input logic lst);
        res_t r;
        r.res_a = clamp(a);
        r.res_b = clamp(b);
        r.res_c = clamp(c);
        r.res_d = clamp(d);
        r.res_scalar = clamp(s);
        r.zero_norm_error = err;
        r.last_of_run = lst;
        return r;
    endfunction

    // queue the rows one request produces
    task automatic predict_rows(input req_t q);
        logic signed [63:0] w, x, y, z, bw, bx, by, bz, one, n, s;
        logic signed [63:0] twx, twy, twz, txx, txy, txz, tyy, tyz, tzz;
        w = q.a_w; x = q.a_x; y = q.a_y; z = q.a_z;
        bw = q.b_w; bx = q.b_x; by = q.b_y; bz = q.b_z;
        one = 64'sd1 <<< FB;
        n = qmul(w, w) + qmul(x, x) + qmul(y, y) + qmul(z, z);
        case (q.req_type)
            OP_MUL:
                rows_due.push_back(mk_row(
                    qmul(w, bw) - qmul(x, bx) - qmul(y, by) - qmul(z, bz),
                    qmul(w, bx) + qmul(x, bw) + qmul(y, bz) - qmul(z, by),
                    qmul(w, by) + qmul(y, bw) + qmul(z, bx) - qmul(x, bz),
                    qmul(w, bz) + qmul(z, bw) + qmul(x, by) - qmul(y, bx),
                    0, 1'b0, 1'b1));
            OP_ADD:
                rows_due.push_back(mk_row(w + bw, x + bx, y + by, z + bz, 0, 1'b0, 1'b1));
            OP_SCALE:
                rows_due.push_back(mk_row(qmul(bw, w), qmul(bw, x), qmul(bw, y),
                                          qmul(bw, z), 0, 1'b0, 1'b1));
            OP_DOT:
                rows_due.push_back(mk_row(0, 0, 0, 0,
                    qmul(w, bw) + qmul(x, bx) + qmul(y, by) + qmul(z, bz), 1'b0, 1'b1));
            OP_INV:
                if (n <= 0)
                    rows_due.push_back(mk_row(0, 0, 0, 0, 0, 1'b1, 1'b1));
                else
                    rows_due.push_back(mk_row((w * one) / n, (-x * one) / n,
                                              (-y * one) / n, (-z * one) / n,
                                              0, 1'b0, 1'b1));
            OP_NORM:
                if (n <= 0)
                    rows_due.push_back(mk_row(0, 0, 0, 0, 0, 1'b1, 1'b1));
                else
                begin
                    s = 2 * $signed(floor_sqrt(n << (FB - 2)));
                    rows_due.push_back(mk_row((w * one) / s, (x * one) / s,
                                              (y * one) / s, (z * one) / s,
                                              n, 1'b0, 1'b1));
                end
            OP_MAT:
            begin
                twx = 2 * qmul(x, w); twy = 2 * qmul(y, w); twz = 2 * qmul(z, w);
                txx = 2 * qmul(x, x); txy = 2 * qmul(y, x); txz = 2 * qmul(z, x);
                tyy = 2 * qmul(y, y); tyz = 2 * qmul(z, y); tzz = 2 * qmul(z, z);
                rows_due.push_back(mk_row(one - (tyy + tzz), txy + twz, txz - twy,
                                          0, 0, 1'b0, 1'b0));
                rows_due.push_back(mk_row(txy - twz, one - (txx + tzz), tyz + twx,
                                          0, 0, 1'b0, 1'b0));
                rows_due.push_back(mk_row(txz + twy, tyz - twx, one - (txx + tyy),
                                          0, 0, 1'b0, 1'b1));
            end
            default:
                rows_due.push_back(mk_row(0, 0, 0, 0, 0, 1'b0, 1'b1));
        endcase
    endtask

    assign pending = rows_due.size();

    initial
    begin
        errors = 0;
        rows_seen = 0;
    end

    // requests are predicted before rows are compared in the same edge
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n)
        begin
            if (req_valid && req_ready)
                predict_rows(req_data);
            if (res_valid && res_ready)
            begin
                rows_seen = rows_seen + 1;
                if (rows_due.size() == 0)
                begin
                    errors = errors + 1;
                    if (errors <= 10)
                        $display("unexpected result row %h", res_data);
                end
                else
                begin
                    want = rows_due.pop_front();
                    if (want !== res_data)
                    begin
                        errors = errors + 1;
                        if (errors <= 10)
                        begin
                            $display("row mismatch at %0t", $realtime);
                            $display("  exp a=%h b=%h c=%h d=%h s=%h err=%b last=%b",
                                     want.res_a, want.res_b, want.res_c, want.res_d,
                                     want.res_scalar, want.zero_norm_error,
                                     want.last_of_run);
                            $display("  got a=%h b=%h c=%h d=%h s=%h err=%b last=%b",
                                     res_data.res_a, res_data.res_b, res_data.res_c,
                                     res_data.res_d, res_data.res_scalar,
                                     res_data.zero_norm_error, res_data.last_of_run);
                        end
                    end
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: test/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Drives the quaternion unit with directed corner requests and random bursts
// of every opcode under receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
    import qau_pkg::*;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req_data;
    logic res_valid;
    logic res_ready;
    res_t res_data;
    int   errors;
    int   pending;
    int   rows_seen;
    int   sent;

    localparam logic signed [31:0] Q_ONE  = 32'sh1000_0000;
    localparam logic signed [31:0] Q_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN  = 32'sh8000_0000;
    localparam logic signed [31:0] Q_TINY = 32'sh0000_1000;

    quaternion_arithmetic_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data)
    );

    qau_scoreboard chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_data  (res_data),
        .errors    (errors),
        .pending   (pending),
        .rows_seen (rows_seen)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    // receiver: alternating stretches of free flow and random stalls
    initial
    begin
        int mode;
        int len;
        res_ready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 2);
            len = $urandom_range(1, 40);
            repeat (len)
            begin
                @(negedge clk);
                case (mode)
                    0: res_ready <= 1'b1;
                    1: res_ready <= ($urandom_range(0, 3) != 0);
                    default: res_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // random component, biased toward magnitudes that keep results in range
    function automatic logic signed [31:0] rand_comp();
        logic signed [31:0] v;
        case ($urandom_range(0, 7))
            0: v = $urandom;
            1: v = Q_MAX;
            2: v = Q_MIN;
            3: v = 0;
            default: v = $signed($urandom) >>> $urandom_range(2, 8);
        endcase
        return v;
    endfunction

    // hold the request until accepted; valid stays high across back-to-back items,
    // otherwise it drops for one cycle before the next request
    task automatic send(input logic [2:0] op, input logic signed [31:0] aw, ax, ay, az,
                        input logic signed [31:0] bw, bx, by, bz, input bit keep);
        req_t r;
        r.req_type = op;
        r.a_w = aw; r.a_x = ax; r.a_y = ay; r.a_z = az;
        r.b_w = bw; r.b_x = bx; r.b_y = by; r.b_z = bz;
        req_data <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        sent = sent + 1;
        @(negedge clk);
        if (!keep)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic send_random(input bit keep);
        logic [2:0] op;
        op = ($urandom_range(0, 30) == 0) ? OP_RSVD : 3'($urandom_range(0, 6));
        send(op, rand_comp(), rand_comp(), rand_comp(), rand_comp(),
             rand_comp(), rand_comp(), rand_comp(), rand_comp(), keep);
    endtask

    initial
    begin
        int burst;
        int wait_cycles;
        rst_n = 1'b0;
        req_valid = 1'b0;
        req_data = '0;
        sent = 0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed corners: each opcode, unit, extremes, zero norm, all bits
        send(OP_MUL, Q_ONE, 0, 0, 0, 0, Q_ONE, 0, 0, 1'b0);
        send(OP_MUL, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MIN, Q_MIN, Q_MAX, Q_MAX, 1'b1);
        send(OP_ADD, Q_MAX, Q_MIN, Q_ONE, -1, Q_MAX, Q_MIN, -1, 1, 1'b1);
        send(OP_ADD, -1, -1, -1, -1, -1, -1, -1, -1, 1'b0);
        send(OP_SCALE, Q_ONE, -Q_ONE, Q_MAX, Q_MIN, Q_MIN, 0, 0, 0, 1'b0);
        send(OP_SCALE, 1, 2, 3, 4, Q_ONE >>> 1, -1, -1, -1, 1'b1);
        send(OP_DOT, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, 1'b1);
        send(OP_DOT, Q_MIN, Q_ONE, -Q_ONE, 5, Q_MAX, Q_ONE, Q_ONE, 7, 1'b0);
        send(OP_INV, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 1'b0);
        send(OP_INV, 0, 0, 0, 0, -1, -1, -1, -1, 1'b0);
        send(OP_INV, 1, -1, 1, 0, 0, 0, 0, 0, 1'b0);
        send(OP_INV, Q_TINY, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send(OP_INV, Q_MIN, Q_MAX, Q_MIN, Q_MAX, 0, 0, 0, 0, 1'b0);
        send(OP_NORM, Q_ONE, Q_ONE, Q_ONE, Q_ONE, 0, 0, 0, 0, 1'b0);
        send(OP_NORM, 0, 0, 0, 0, 0, 0, 0, 0, 1'b0);
        send(OP_NORM, 3, -3, 0, 0, 0, 0, 0, 0, 1'b0);
        send(OP_NORM, Q_MIN, Q_MIN, Q_MIN, Q_MIN, 0, 0, 0, 0, 1'b0);
        send(OP_NORM, Q_TINY, -Q_TINY, Q_TINY, 0, 0, 0, 0, 0, 1'b0);
        send(OP_MAT, Q_ONE, 0, 0, 0, 0, 0, 0, 0, 1'b1);
        send(OP_MAT, Q_ONE >>> 1, Q_ONE >>> 1, -(Q_ONE >>> 1), Q_ONE >>> 1,
             0, 0, 0, 0, 1'b1);
        send(OP_MAT, Q_MAX, Q_MIN, Q_MAX, Q_MIN, 0, 0, 0, 0, 1'b0);
        send(OP_RSVD, Q_MAX, Q_MAX, Q_MAX, Q_MAX, -1, -1, -1, -1, 1'b0);

        // random bursts with random gaps
        while (sent < 195)
        begin
            burst = $urandom_range(1, 12);
            for (int i = 0; i < burst; i++)
                send_random(i != burst - 1);
            wait_cycles = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
            repeat (wait_cycles) @(negedge clk);
        end

        while (pending != 0)
            @(posedge clk);
        repeat (200) @(posedge clk);

        $display("sent %0d requests covering all opcodes, zero norms and saturation;", sent);
        $display("compared %0d result rows under random stalls", rows_seen);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // safety limit: about 200 requests plus stalls, many times over
    initial
    begin
        #20ms;
        $display("timeout: %0d rows still pending", pending);
        $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
sv/qau_pkg.sv
sv/qau_mul_lane.sv
sv/qau_isqrt.sv
sv/qau_div_lane.sv
sv/quaternion_arithmetic_unit.sv
sv/qau_checker.sv
test/qau_checker.sv
test/tb.sv
